[rtl/core/tgsg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgsg_pkg
// Shared types, command codes and constants of the turtle graphics segment
// generator: command and result beats, pipeline control and the sine ROM scale.
// ----------------------------------------------------------------------------
package tgsg_pkg;

    localparam int SINE_ENTRIES_DEF = 256;
    localparam int HEADING_BITS_DEF = 16;

    localparam int POS_W   = 24;
    localparam int TRIG_W  = 16;
    localparam int DEG_W   = 16;
    localparam int ACT_W   = 3;
    localparam int STAGES  = 5;

    localparam int DEG_SCALE = 180;
    localparam int DEG_FRAC  = 64;

    localparam longint HALF_PI_Q30 = 64'sd1686629713;

    localparam logic [ACT_W-1:0] ACT_MOVE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TURN     = 3'd1;
    localparam logic [ACT_W-1:0] ACT_PEN_UP   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PEN_DOWN = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESET    = 3'd4;

    localparam logic KIND_SEGMENT = 1'b0;
    localparam logic KIND_CLEAR   = 1'b1;

    typedef struct packed {
        logic [ACT_W-1:0]        action;
        logic signed [POS_W-1:0] move_length;
        logic signed [DEG_W-1:0] turn_degrees;
    } t_cmd;

    typedef struct packed {
        logic                    out_kind;
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [POS_W-1:0] end_x;
        logic signed [POS_W-1:0] end_y;
    } t_result;

    // en[k] loads stage k (en[STAGES] loads the result register)
    typedef struct packed {
        logic [STAGES:0]   en;
        logic [STAGES-1:0] vld;
    } t_pipe_ctrl;

endpackage

[rtl/core/tgsg_heading.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgsg_heading
// Input register, turn angle conversion and heading state; hands the sine
// phase of the current heading to the trig stage.
// ----------------------------------------------------------------------------
module tgsg_heading #(
    parameter int SINE_ENTRIES = tgsg_pkg::SINE_ENTRIES_DEF,
    parameter int HEADING_BITS = tgsg_pkg::HEADING_BITS_DEF,
    localparam int PW = $clog2(4 * SINE_ENTRIES)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tgsg_pkg::t_pipe_ctrl i_ctrl,
    input  tgsg_pkg::t_cmd       i_cmd,
    output tgsg_pkg::t_cmd       o_cmd,
    output logic [PW-1:0]        o_phase
);

    localparam int HB       = HEADING_BITS;
    localparam int NW       = HB + 7;
    localparam int RW       = NW - 5;
    localparam int DIV_ODD  = (tgsg_pkg::DEG_SCALE * tgsg_pkg::DEG_FRAC) / 256;
    localparam int HALF_ODD = (tgsg_pkg::DEG_SCALE * tgsg_pkg::DEG_FRAC / 2) / 256;
    localparam logic [RW-1:0] RECIP    = RW'((64'd1 << NW) / DIV_ODD);
    localparam logic [NW-1:0] DIV_C    = NW'(DIV_ODD);
    localparam logic [NW-1:0] BIAS_C   = NW'(HALF_ODD);
    localparam logic [HB+PW-1:0] PHASE_K = (HB + PW)'(4 * SINE_ENTRIES);

    tgsg_pkg::t_cmd r_s0;
    tgsg_pkg::t_cmd r_s1_cmd;
    logic           r_s1_neg;
    logic [NW-1:0]  r_s1_num;
    logic [NW+RW-1:0] r_s1_prod;
    logic [HB-1:0]  r_heading;
    logic [HB-1:0]  n_heading;
    tgsg_pkg::t_cmd r_s2_cmd;
    logic [PW-1:0]  r_s2_phase;

    logic [tgsg_pkg::DEG_W-1:0] w_mag;
    logic [NW-1:0]    w_num;
    logic [NW+RW-1:0] w_prod;
    logic [RW-1:0]    w_q0;
    logic [NW-1:0]    w_rem;
    logic [RW-1:0]    w_q;
    logic [HB-1:0]    w_qh;
    logic [HB-1:0]    w_delta;
    logic [HB+PW-1:0] w_phase_full;

    always_comb begin
        w_mag  = r_s0.turn_degrees[tgsg_pkg::DEG_W-1] ?
                 tgsg_pkg::DEG_W'(-r_s0.turn_degrees) : tgsg_pkg::DEG_W'(r_s0.turn_degrees);
        w_num  = (NW'(w_mag) << (HB - 9)) + BIAS_C;
        w_prod = (NW + RW)'(w_num) * (NW + RW)'(RECIP);
    end

    always_comb begin
        w_q0    = r_s1_prod[NW+RW-1:NW];
        w_rem   = r_s1_num - NW'(NW'(w_q0) * DIV_C);
        w_q     = w_q0 + RW'(w_rem >= DIV_C);
        w_qh    = w_q[HB-1:0];
        w_delta = r_s1_neg ? (~w_qh + HB'(1)) : w_qh;
    end

    always_comb begin
        n_heading = r_heading;
        if (i_ctrl.vld[1] && i_ctrl.en[2]) begin
            if (r_s1_cmd.action == tgsg_pkg::ACT_TURN) begin
                n_heading = r_heading + w_delta;
            end else if (r_s1_cmd.action == tgsg_pkg::ACT_RESET) begin
                n_heading = '0;
            end
        end
    end

    assign w_phase_full = (HB + PW)'(r_heading) * PHASE_K;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heading <= '0;
        end else begin
            r_heading <= n_heading;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[0]) begin
            r_s0 <= i_cmd;
        end
        if (i_ctrl.en[1]) begin
            r_s1_cmd  <= r_s0;
            r_s1_neg  <= r_s0.turn_degrees[tgsg_pkg::DEG_W-1];
            r_s1_num  <= w_num;
            r_s1_prod <= w_prod;
        end
        if (i_ctrl.en[2]) begin
            r_s2_cmd   <= r_s1_cmd;
            r_s2_phase <= w_phase_full[HB+PW-1:HB];
        end
    end

    assign o_cmd   = r_s2_cmd;
    assign o_phase = r_s2_phase;

endmodule

[rtl/core/tgsg_trig.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgsg_trig
// Quadrant decode and quarter-wave sine ROM: cosine and sine of the heading
// phase in Q1.15.
// ----------------------------------------------------------------------------
module tgsg_trig #(
    parameter int SINE_ENTRIES = tgsg_pkg::SINE_ENTRIES_DEF,
    localparam int PW = $clog2(4 * SINE_ENTRIES)
) (
    input  logic                                i_clk,
    input  tgsg_pkg::t_pipe_ctrl                i_ctrl,
    input  tgsg_pkg::t_cmd                      i_cmd,
    input  logic [PW-1:0]                       i_phase,
    output tgsg_pkg::t_cmd                      o_cmd,
    output logic signed [tgsg_pkg::TRIG_W-1:0]  o_cos,
    output logic signed [tgsg_pkg::TRIG_W-1:0]  o_sin
);

    localparam int TW = tgsg_pkg::TRIG_W;
    localparam int IW = $clog2(SINE_ENTRIES + 1);
    localparam logic [PW:0] Q1 = (PW + 1)'(SINE_ENTRIES);
    localparam logic [PW:0] Q2 = (PW + 1)'(2 * SINE_ENTRIES);
    localparam logic [PW:0] Q3 = (PW + 1)'(3 * SINE_ENTRIES);
    localparam logic [PW:0] Q4 = (PW + 1)'(4 * SINE_ENTRIES);

    logic [TW-2:0] w_rom [SINE_ENTRIES+1];

    // sine series in Q30, seven terms, rounded to Q1.15
    for (genvar k = 0; k <= SINE_ENTRIES; k++) begin : g_rom
        localparam longint XK   = tgsg_pkg::HALF_PI_Q30 * k / SINE_ENTRIES;
        localparam longint X2K  = (XK * XK) >>> 30;
        localparam longint T1   = ((XK * X2K) >>> 30) / 6;
        localparam longint T2   = ((T1 * X2K) >>> 30) / 20;
        localparam longint T3   = ((T2 * X2K) >>> 30) / 42;
        localparam longint T4   = ((T3 * X2K) >>> 30) / 72;
        localparam longint T5   = ((T4 * X2K) >>> 30) / 110;
        localparam longint T6   = ((T5 * X2K) >>> 30) / 156;
        localparam longint SUMK = XK - T1 + T2 - T3 + T4 - T5 + T6;
        localparam longint QK   = (((SUMK < 0) ? 64'sd0 : SUMK) + 64'sd16384) >>> 15;
        localparam logic [TW-2:0] ENTRY = (QK > 64'sd32767) ? (TW - 1)'(32767)
                                                            : (TW - 1)'(QK);
        assign w_rom[k] = ENTRY;
    end

    // {negate, rom index} for a phase below four quadrants
    function automatic logic [IW:0] locate(input logic [PW:0] p);
        logic [PW:0] r;
        logic        mirror;
        logic        neg;
        logic [PW:0] idx;
        if (p < Q1) begin
            r = p;      mirror = 1'b0; neg = 1'b0;
        end else if (p < Q2) begin
            r = p - Q1; mirror = 1'b1; neg = 1'b0;
        end else if (p < Q3) begin
            r = p - Q2; mirror = 1'b0; neg = 1'b1;
        end else begin
            r = p - Q3; mirror = 1'b1; neg = 1'b1;
        end
        idx = mirror ? (Q1 - r) : r;
        return {neg, idx[IW-1:0]};
    endfunction

    logic [PW:0]   w_pc;
    logic [IW:0]   w_loc_c;
    logic [IW:0]   w_loc_s;
    logic [TW-1:0] w_mag_c;
    logic [TW-1:0] w_mag_s;

    tgsg_pkg::t_cmd           r_s3_cmd;
    logic signed [TW-1:0]     r_cos;
    logic signed [TW-1:0]     r_sin;

    always_comb begin
        w_pc = {1'b0, i_phase} + Q1;
        if (w_pc >= Q4) begin
            w_pc = w_pc - Q4;
        end
        w_loc_c = locate(w_pc);
        w_loc_s = locate({1'b0, i_phase});
        w_mag_c = {1'b0, w_rom[w_loc_c[IW-1:0]]};
        w_mag_s = {1'b0, w_rom[w_loc_s[IW-1:0]]};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[3]) begin
            r_s3_cmd <= i_cmd;
            r_cos    <= w_loc_c[IW] ? -$signed(w_mag_c) : $signed(w_mag_c);
            r_sin    <= w_loc_s[IW] ? -$signed(w_mag_s) : $signed(w_mag_s);
        end
    end

    assign o_cmd = r_s3_cmd;
    assign o_cos = r_cos;
    assign o_sin = r_sin;

endmodule

[rtl/core/tgsg_plot.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgsg_plot
// Step products, position update with saturation, pen state and the result
// register.
// ----------------------------------------------------------------------------
module tgsg_plot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tgsg_pkg::t_pipe_ctrl                i_ctrl,
    input  tgsg_pkg::t_cmd                      i_cmd,
    input  logic signed [tgsg_pkg::TRIG_W-1:0]  i_cos,
    input  logic signed [tgsg_pkg::TRIG_W-1:0]  i_sin,
    output logic                                o_emit,
    output tgsg_pkg::t_result                   o_res
);

    localparam int PV = tgsg_pkg::POS_W;
    localparam int MW = tgsg_pkg::POS_W + tgsg_pkg::TRIG_W;
    localparam int DW = MW - 15;
    localparam int SW = DW + 1;
    localparam logic signed [MW-1:0] HALF_LSB = MW'(16384);
    localparam logic signed [SW-1:0] POS_MAX  = SW'((1 << (PV - 1)) - 1);
    localparam logic signed [SW-1:0] POS_MIN  = -SW'(1 << (PV - 1));

    function automatic logic signed [PV-1:0] step(input logic signed [PV-1:0] pos,
                                                  input logic signed [MW-1:0] prod);
        logic signed [MW-1:0] biased;
        logic signed [SW-1:0] sum;
        biased = prod + HALF_LSB;
        sum    = SW'(pos) + SW'($signed(biased[MW-1:15]));
        if (sum > POS_MAX) begin
            sum = POS_MAX;
        end else if (sum < POS_MIN) begin
            sum = POS_MIN;
        end
        return sum[PV-1:0];
    endfunction

    logic [tgsg_pkg::ACT_W-1:0] r_s4_action;
    logic signed [MW-1:0]       r_prod_x;
    logic signed [MW-1:0]       r_prod_y;
    logic signed [PV-1:0]       r_pos_x;
    logic signed [PV-1:0]       r_pos_y;
    logic                       r_pen;
    tgsg_pkg::t_result          r_res;

    logic signed [PV-1:0] w_nx;
    logic signed [PV-1:0] w_ny;
    logic                 w_take;

    assign w_nx   = step(r_pos_x, r_prod_x);
    assign w_ny   = step(r_pos_y, r_prod_y);
    assign o_emit = ((r_s4_action == tgsg_pkg::ACT_MOVE) && r_pen) ||
                    (r_s4_action == tgsg_pkg::ACT_RESET);
    assign w_take = i_ctrl.vld[4] && i_ctrl.en[5];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_pen   <= 1'b1;
        end else if (w_take) begin
            case (r_s4_action)
                tgsg_pkg::ACT_MOVE: begin
                    r_pos_x <= w_nx;
                    r_pos_y <= w_ny;
                end
                tgsg_pkg::ACT_PEN_UP: begin
                    r_pen <= 1'b0;
                end
                tgsg_pkg::ACT_PEN_DOWN: begin
                    r_pen <= 1'b1;
                end
                tgsg_pkg::ACT_RESET: begin
                    r_pos_x <= '0;
                    r_pos_y <= '0;
                    r_pen   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en[4]) begin
            r_s4_action <= i_cmd.action;
            r_prod_x    <= MW'(i_cmd.move_length) * MW'(i_cos);
            r_prod_y    <= MW'(i_cmd.move_length) * MW'(i_sin);
        end
        if (w_take && o_emit) begin
            if (r_s4_action == tgsg_pkg::ACT_RESET) begin
                r_res.out_kind <= tgsg_pkg::KIND_CLEAR;
                r_res.start_x  <= '0;
                r_res.start_y  <= '0;
                r_res.end_x    <= '0;
                r_res.end_y    <= '0;
            end else begin
                r_res.out_kind <= tgsg_pkg::KIND_SEGMENT;
                r_res.start_x  <= r_pos_x;
                r_res.start_y  <= r_pos_y;
                r_res.end_x    <= w_nx;
                r_res.end_y    <= w_ny;
            end
        end
    end

    assign o_res = r_res;

endmodule

[rtl/core/turtle_graphics_segment_generator_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// turtle_graphics_segment_generator_top
// Turtle command processor: keeps position, heading and pen, and emits a
// line segment for each pen-down move and a clear beat for each reset.
// ----------------------------------------------------------------------------
// One command beat is taken every cycle unless the input stage holds; its
// result beat is registered after stages 1 to 4. The pipeline runs input
// register, turn conversion (multiply by the reciprocal of the degree scale),
// heading update with sine phase, quarter-wave ROM lookup, step multiplies,
// then position update and result register. A stage holds only while it is
// full and the stage after it holds, so commands keep flowing into empty
// stages while a result waits to be taken. Turn, pen up, pen down and unused
// codes produce no beat.
// ----------------------------------------------------------------------------
module turtle_graphics_segment_generator_top #(
    parameter int SINE_ENTRIES = tgsg_pkg::SINE_ENTRIES_DEF,
    parameter int HEADING_BITS = tgsg_pkg::HEADING_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    input  tgsg_pkg::t_cmd    i_cmd,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output tgsg_pkg::t_result o_res
);

    localparam int PW = $clog2(4 * SINE_ENTRIES);
    localparam int NS = tgsg_pkg::STAGES;

    logic [NS-1:0]        r_vld;
    logic [NS-1:0]        n_vld;
    logic                 r_out_valid;
    logic                 n_out_valid;
    tgsg_pkg::t_pipe_ctrl w_ctrl;

    tgsg_pkg::t_cmd       w_s2_cmd;
    logic [PW-1:0]        w_s2_phase;
    tgsg_pkg::t_cmd       w_s3_cmd;
    logic signed [tgsg_pkg::TRIG_W-1:0] w_cos;
    logic signed [tgsg_pkg::TRIG_W-1:0] w_sin;
    logic                 w_emit;

    always_comb begin
        w_ctrl.vld     = r_vld;
        w_ctrl.en[NS]  = !r_out_valid || i_res_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_ctrl.en[k] = !r_vld[k] || w_ctrl.en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_ctrl.en[0] ? i_cmd_valid : r_vld[0];
        for (int k = 1; k < NS; k++) begin
            n_vld[k] = w_ctrl.en[k] ? r_vld[k-1] : r_vld[k];
        end
        n_out_valid = w_ctrl.en[NS] ? (r_vld[NS-1] && w_emit) : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
        end
    end

    tgsg_heading #(
        .SINE_ENTRIES (SINE_ENTRIES),
        .HEADING_BITS (HEADING_BITS)
    ) u_heading (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_cmd   (i_cmd),
        .o_cmd   (w_s2_cmd),
        .o_phase (w_s2_phase)
    );

    tgsg_trig #(
        .SINE_ENTRIES (SINE_ENTRIES)
    ) u_trig (
        .i_clk   (i_clk),
        .i_ctrl  (w_ctrl),
        .i_cmd   (w_s2_cmd),
        .i_phase (w_s2_phase),
        .o_cmd   (w_s3_cmd),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    tgsg_plot u_plot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_ctrl),
        .i_cmd   (w_s3_cmd),
        .i_cos   (w_cos),
        .i_sin   (w_sin),
        .o_emit  (w_emit),
        .o_res   (o_res)
    );

    assign o_cmd_ready = w_ctrl.en[0];
    assign o_res_valid = r_out_valid;

endmodule
